// ----- hdl/stream_find_and_replace_assert.svh -----
// ----------------------------------------------------------------------------
// stream_find_and_replace_assert.svh
// Assertion macros for the stream find-and-replace modules (used by sfr_queue)
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find-and-replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } sfr_reg_idx_t;

  // configuration seen by the front end
  typedef struct packed {
    logic [7:0][7:0] pattern;
    logic [3:0]      pat_len;
    logic [7:0][7:0] replacement;
    logic [3:0]      rep_len;
    logic            clear;
  } sfr_cfg_t;

  // one job: bytes to emit for one accepted input transfer
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      count;
    logic            text_end;
  } sfr_job_t;

  function automatic logic [3:0] sat_pat_len(input logic [3:0] raw);
    logic [3:0] n;
    n = raw;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MAX_PATTERN)) n = 4'(MAX_PATTERN);
    return n;
  endfunction

  function automatic logic [3:0] sat_rep_len(input logic [3:0] raw);
    logic [3:0] n;
    n = raw;
    if (n > 4'(MAX_REPLACEMENT)) n = 4'(MAX_REPLACEMENT);
    return n;
  endfunction

endpackage

// ----- hdl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Accepts text bytes, keeps the match window and builds a job for each transfer that yields results or ends a text
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_text_byte,
  input  logic              in_final_byte,
  input  logic              q_full,
  output logic              q_push,
  output sfr_pkg::sfr_job_t q_data
);
  import sfr_pkg::*;

  logic [7:0][7:0] win_r, win_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [7:0][7:0] w_app;
  logic            accept;
  logic            full;
  logic            match;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      w_app[k] = (3'(k) == fill_r) ? in_text_byte : win_r[k];
    end
    full  = ({1'b0, fill_r} + 4'd1) == cfg.pat_len;
    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((4'(k) < cfg.pat_len) && (w_app[k] != cfg.pattern[k])) match = 1'b0;
    end
  end

  always_comb begin
    q_data.text_end = in_final_byte;
    q_data.bytes    = w_app;
    win_nxt         = w_app;
    fill_nxt        = fill_r;
    if (full && match) begin
      q_data.bytes = cfg.replacement;
      q_data.count = cfg.rep_len;
      fill_nxt     = 3'd0;
    end else if (full) begin
      q_data.count = in_final_byte ? cfg.pat_len : 4'd1;
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        win_nxt[k] = w_app[k + 1];
      end
    end else begin
      q_data.count = in_final_byte ? ({1'b0, fill_r} + 4'd1) : 4'd0;
      fill_nxt     = fill_r + 3'd1;
    end
    if (in_final_byte) fill_nxt = 3'd0;
    q_push = accept & ((q_data.count != 4'd0) | in_final_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
    end else if (cfg.clear) begin
      fill_r <= 3'd0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- hdl/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue between the front end and the emitter
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_job_t push_data,
  input  logic              pop,
  output sfr_pkg::sfr_job_t pop_data,
  output logic              full,
  output logic              empty
);
  import sfr_pkg::*;

  `include "stream_find_and_replace_assert.svh"

  sfr_job_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `SFR_ASSERT_NOW(a_no_overflow, push, !full)
  `SFR_ASSERT_NOW(a_no_underflow, pop, !empty)
  `SFR_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

// ----- hdl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Emitter: while out_stall is low, plays out the bytes of each queued job, one result per cycle
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sfr_pkg::sfr_job_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_result_byte,
  output logic              out_byte_valid,
  output logic              out_end_of_run,
  output logic              out_end_of_text
);
  import sfr_pkg::*;

  sfr_job_t   cur_r;
  logic       busy_r;
  logic [2:0] idx_r;
  logic       out_fire;
  logic       last_byte;

  assign out_valid       = busy_r;
  assign out_byte_valid  = cur_r.count != 4'd0;
  assign out_result_byte = out_byte_valid ? cur_r.bytes[idx_r] : 8'd0;
  assign last_byte       = ~out_byte_valid | (({1'b0, idx_r} + 4'd1) == cur_r.count);
  assign out_end_of_run  = last_byte;
  assign out_end_of_text = last_byte & cur_r.text_end;
  assign out_fire        = busy_r & ~out_stall;
  assign q_pop           = (~busy_r | (out_fire & last_byte)) & ~q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (!busy_r || (out_fire && last_byte)) begin
      busy_r <= ~q_empty;
      idx_r  <= 3'd0;
    end else if (out_fire) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

// ----- hdl/stream_find_and_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Replaces every leftmost non-overlapping pattern match in a byte stream
// ----------------------------------------------------------------------------
// Text enters one byte per transfer on in_* (in_final_byte marks the last
// byte of a text). Rewritten bytes leave one per transfer on out_*; a bare
// end mark (out_byte_valid low) closes a text that leaves nothing to emit.
// out_end_of_run flags the last result caused by one input transfer and
// out_end_of_text the last result of the whole text.
// Pattern (1 to 8 bytes) and replacement (0 to 8 bytes) are set over the
// APB port, 64-bit registers at byte addresses 0, 8, 16 and 24; writing the
// pattern length empties the match window.
// When the block is idle, the first result of an input passes through the job
// queue and the emitter's job register. The front end takes one byte per cycle
// while the 4-entry job queue has room; while the receiver does not stall, the
// emitter gives one result per cycle, so one input's results leave back to back.
// When the receiver stalls, the current result holds and jobs pile up in the
// queue; in_stall rises once the queue is full.
// Reset empties the window and the queue and restores pattern length 1 and
// replacement length 0.
// ----------------------------------------------------------------------------
module stream_find_and_replace (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_result_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_run,
  output logic        out_end_of_text,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import sfr_pkg::*;

  logic [63:0]  pattern_bytes_r;
  logic [3:0]   pattern_length_r;
  logic [63:0]  replacement_bytes_r;
  logic [3:0]   replacement_length_r;
  sfr_reg_idx_t reg_idx;
  logic         wr_en;
  sfr_cfg_t     cfg;
  logic         q_full, q_empty, q_push, q_pop;
  sfr_job_t     q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = sfr_reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r      <= 64'd0;
      pattern_length_r     <= 4'd1;
      replacement_bytes_r  <= 64'd0;
      replacement_length_r <= 4'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_BYTES:      pattern_bytes_r      <= pwdata;
        REG_PATTERN_LENGTH:     pattern_length_r     <= pwdata[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes_r  <= pwdata;
        REG_REPLACEMENT_LENGTH: replacement_length_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_BYTES:      prdata = pattern_bytes_r;
      REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length_r};
      REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_r;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length_r};
      default:                prdata = 64'd0;
    endcase
  end

  always_comb begin
    cfg.pattern     = pattern_bytes_r;
    cfg.pat_len     = sat_pat_len(pattern_length_r);
    cfg.replacement = replacement_bytes_r;
    cfg.rep_len     = sat_rep_len(replacement_length_r);
    cfg.clear       = wr_en & (reg_idx == REG_PATTERN_LENGTH);
  end

  sfr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_text (out_end_of_text)
  );

endmodule

// ----- tb/sv/tb_stream_find_and_replace.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace
// Self-checking testbench for the stream find-and-replace block
// ----------------------------------------------------------------------------
// A short directed table covers the reset settings, the extreme bytes, a
// bare end mark, deletion and the saturated pattern and replacement lengths.
// Random texts follow: each phase programs a new pattern and replacement
// over the APB port. The texts are built mostly from the pattern's own
// alphabet, so matches, near misses and flushes happen often. Every accepted
// input runs through a cycle-free model of the window. The expected results
// are queued and checked field by field against each output transfer.
// Back-pressure runs in three modes. Two long receiver hold-offs fill the
// job queue, and one sender pause lets the output drain.
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace;
  import sfr_pkg::*;

  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 26;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       byte_valid;
    logic       end_of_run;
    logic       end_of_text;
  } text_result_t;

  typedef struct {
    bit           is_write;
    sfr_reg_idx_t reg_sel;
    logic [63:0]  value;
    logic [7:0]   text_byte;
    bit           final_byte;
    bit           typed;
    text_result_t typed_res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_result_byte;
  logic        out_byte_valid;
  logic        out_end_of_run;
  logic        out_end_of_text;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // model of the block's registers and match window
  logic [63:0] pattern_reg = '0;
  logic [3:0]  pat_len_raw = 4'd1;
  logic [63:0] replacement_reg = '0;
  logic [3:0]  rep_len_raw = 4'd0;
  logic [7:0]  window_bytes [MAX_PATTERN];
  int          window_fill = 0;

  text_result_t step_results [$];
  text_result_t awaited_results [$];
  stim_row_t    directed_rows [$];
  logic [7:0]   text_q [$];

  int err_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int alpha_base;
  int alpha_size;
  bit alpha_wide;

  stream_find_and_replace uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_text (out_end_of_text),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic text_result_t make_result(input logic [7:0] b, input logic v,
                                               input logic eor, input logic eot);
    text_result_t r;
    r.result_byte = b;
    r.byte_valid  = v;
    r.end_of_run  = eor;
    r.end_of_text = eot;
    return r;
  endfunction

  function automatic int eff_pat_len();
    if (pat_len_raw == 4'd0) return 1;
    if (pat_len_raw > MAX_PATTERN) return MAX_PATTERN;
    return pat_len_raw;
  endfunction

  // results caused by one text byte, left in step_results
  task automatic rewrite_byte(input logic [7:0] b, input bit fin);
    int plen;
    int rlen;
    int i;
    bit hit;
    text_result_t r;
    step_results.delete();
    plen = eff_pat_len();
    rlen = (rep_len_raw > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len_raw;
    if (window_fill >= plen) window_fill = 0;
    window_bytes[window_fill] = b;
    window_fill++;
    if (window_fill == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (window_bytes[i] != pattern_reg[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++)
          step_results.push_back(make_result(replacement_reg[8*i +: 8], 1'b1, 1'b0, 1'b0));
        window_fill = 0;
      end else begin
        step_results.push_back(make_result(window_bytes[0], 1'b1, 1'b0, 1'b0));
        for (i = 0; i < plen - 1; i++) window_bytes[i] = window_bytes[i + 1];
        window_fill = plen - 1;
      end
    end
    if (fin) begin
      for (i = 0; i < window_fill; i++)
        step_results.push_back(make_result(window_bytes[i], 1'b1, 1'b0, 1'b0));
      window_fill = 0;
      if (step_results.size() == 0) step_results.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b0));
      r = step_results.pop_back();
      r.end_of_text = 1'b1;
      step_results.push_back(r);
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.end_of_run = 1'b1;
      step_results.push_back(r);
    end
  endtask

  task automatic write_reg(input sfr_reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    psel     = 1'b1;
    pwrite   = 1'b1;
    penable  = 1'b0;
    paddr    = {idx, 3'b000};
    pwdata   = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_PATTERN_BYTES:      pattern_reg = value;
      REG_PATTERN_LENGTH: begin
        pat_len_raw = value[3:0];
        window_fill = 0;
      end
      REG_REPLACEMENT_BYTES:  replacement_reg = value;
      REG_REPLACEMENT_LENGTH: rep_len_raw = value[3:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fin, input bit typed,
                           input text_result_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_text_byte  = b;
    in_final_byte = fin;
    do @(posedge clk); while (in_stall);
    rewrite_byte(b, fin);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
  endtask

  function automatic void add_write(input sfr_reg_idx_t idx, input logic [63:0] value);
    stim_row_t row;
    row = '{reg_sel: REG_PATTERN_BYTES, default: '0};
    row.is_write = 1'b1;
    row.reg_sel  = idx;
    row.value    = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit fin, input bit typed,
                                   input text_result_t res);
    stim_row_t row;
    row = '{reg_sel: REG_PATTERN_BYTES, default: '0};
    row.text_byte  = b;
    row.final_byte = fin;
    row.typed      = typed;
    row.typed_res  = res;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if (alpha_wide) return 8'($urandom_range(255));
    return 8'(alpha_base + $urandom_range(alpha_size - 1));
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endfunction

  // receiver side of the result channel
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    text_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected transfer: result_byte %0h", out_result_byte);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("result_byte", want.result_byte, out_result_byte);
        check_field("byte_valid", want.byte_valid, out_byte_valid);
        check_field("end_of_run", want.end_of_run, out_end_of_run);
        check_field("end_of_text", want.end_of_text, out_end_of_text);
      end
    end
  end

  initial begin
    text_result_t none;
    int phase;
    int sent;
    int tlen;
    int plen;
    int r;
    int i;
    logic [63:0] word;
    logic [3:0] plen_raw;
    logic [3:0] rlen_raw;

    none          = make_result(8'h00, 1'b0, 1'b0, 1'b0);
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_text_byte  = 8'h00;
    in_final_byte = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: one-byte pattern 00, empty replacement
    add_byte(8'h41, 1'b1, 1'b1, make_result(8'h41, 1'b1, 1'b1, 1'b1));
    add_byte(8'h00, 1'b1, 1'b1, make_result(8'h00, 1'b0, 1'b1, 1'b1));
    add_byte(8'hFF, 1'b1, 1'b1, make_result(8'hFF, 1'b1, 1'b1, 1'b1));
    add_write(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A563_6261);
    add_write(REG_PATTERN_LENGTH, 64'd3);
    add_write(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958);
    add_write(REG_REPLACEMENT_LENGTH, 64'd2);
    add_byte("x", 1'b0, 1'b0, none);
    add_byte("a", 1'b0, 1'b0, none);
    add_byte("b", 1'b0, 1'b0, none);
    add_byte("c", 1'b0, 1'b0, none);
    add_byte("y", 1'b1, 1'b0, none);
    add_byte("a", 1'b0, 1'b0, none);
    add_byte("a", 1'b0, 1'b0, none);
    add_byte("b", 1'b0, 1'b0, none);
    add_byte("c", 1'b1, 1'b0, none);
    // deletion leaving nothing to emit
    add_write(REG_REPLACEMENT_LENGTH, 64'd0);
    add_byte("a", 1'b0, 1'b0, none);
    add_byte("b", 1'b0, 1'b0, none);
    add_byte("c", 1'b1, 1'b1, make_result(8'h00, 1'b0, 1'b1, 1'b1));
    // zero and oversized lengths saturate
    add_write(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    add_write(REG_REPLACEMENT_LENGTH, 64'd15);
    add_write(REG_PATTERN_LENGTH, 64'd0);
    add_byte(8'hFF, 1'b1, 1'b0, none);
    add_write(REG_PATTERN_LENGTH, 64'd15);
    for (i = 0; i < 7; i++) add_byte(8'hFF, 1'b0, 1'b0, none);
    add_byte(8'h00, 1'b1, 1'b0, none);

    send_gap_pct   = 13;
    recv_stall_pct = 54;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_write)
        write_reg(directed_rows[k].reg_sel, directed_rows[k].value);
      else
        send_byte(directed_rows[k].text_byte, directed_rows[k].final_byte,
                  directed_rows[k].typed, directed_rows[k].typed_res);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_gap_pct   = 13;
          recv_stall_pct = 54;
        end
        1: begin
          send_gap_pct   = 54;
          recv_stall_pct = 13;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      alpha_base = $urandom_range(255);
      alpha_size = $urandom_range(2, 3);
      alpha_wide = ($urandom_range(3) == 0);

      word = {$urandom, $urandom};
      for (i = 0; i < MAX_PATTERN; i++) word[8*i +: 8] = pick_text_byte();
      r = $urandom_range(99);
      if (phase == 0) plen_raw = 4'd1;
      else if (phase == PHASES - 1) plen_raw = 4'd8;
      else if (r < 12) plen_raw = 4'($urandom_range(9, 16));
      else plen_raw = 4'($urandom_range(1, 8));
      r = $urandom_range(99);
      if (phase == 0) rlen_raw = 4'd0;
      else if (phase == PHASES - 1) rlen_raw = 4'd8;
      else if (r < 12) rlen_raw = 4'($urandom_range(9, 15));
      else rlen_raw = 4'($urandom_range(0, 8));
      write_reg(REG_PATTERN_BYTES, word);
      write_reg(REG_PATTERN_LENGTH, {60'($urandom), plen_raw});
      write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(REG_REPLACEMENT_LENGTH, {60'($urandom), rlen_raw});

      // long receiver hold-off so the job queue fills
      if (phase == 1 || phase == 4) hold_req = 1'b1;

      plen = eff_pat_len();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        text_q.delete();
        tlen = $urandom_range(1, 12);
        while (text_q.size() < tlen) begin
          r = $urandom_range(99);
          if (r < 35) for (i = 0; i < plen; i++) text_q.push_back(pattern_reg[8*i +: 8]);
          else if (r < 85) text_q.push_back(pick_text_byte());
          else text_q.push_back(8'($urandom_range(255)));
        end
        foreach (text_q[k]) begin
          send_byte(text_q[k], k == text_q.size() - 1, 1'b0, none);
          sent++;
          // sender pause halfway through the phase until the output has drained
          if (phase == 2 && sent == PHASE_ITEMS / 2) begin
            @(negedge clk);
            in_valid = 1'b0;
            while (awaited_results.size() != 0) @(posedge clk);
          end
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/stream_find_and_replace.sv
tb/sv/tb_stream_find_and_replace.sv
